### hdl/prt_pkg.sv
package prt_pkg;

    localparam int NODES          = 16;
    localparam int TABLE_ENTRIES  = 16;
    localparam int LINE_ADDR_BITS = 42;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int NIBBLES = (NODES + 3) / 4;
    localparam int CNT_W   = $clog2(NODES + 1);

    localparam logic [1:0] FUNC_LOCK   = 2'd0;
    localparam logic [1:0] FUNC_UNLOCK = 2'd1;
    localparam logic [1:0] FUNC_MARK   = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_STARVING    = 3'd1;
    localparam logic [2:0] ERR_NOT_HELD    = 3'd2;
    localparam logic [2:0] ERR_TABLE_FULL  = 3'd3;
    localparam logic [2:0] ERR_MARKED      = 3'd4;

    localparam logic ADDR_OWN_NODE = 1'b0;

    typedef struct packed {
        logic [1:0]                func;
        logic [LINE_ADDR_BITS-1:0] line_addr;
        logic [3:0]                node;
        logic                      is_write;
    } prt_req_t;

    typedef struct packed {
        logic       locked;
        logic       may_issue;
        logic       smallest_valid;
        logic [3:0] smallest_node;
        logic       smallest_is_write;
        logic [4:0] starving_count;
        logic [4:0] read_starving_count;
        logic [2:0] error;
    } prt_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_REPORT
    } prt_state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic update;
        logic report;
    } prt_cmd_t;

    typedef struct packed {
        logic rsp_stall;
    } prt_status_t;

    function automatic logic [NODES-1:0] node_onehot(input logic [3:0] n);
        logic [NODES-1:0] v;
        v = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (32'(n) == i)
            begin
                v[i] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] pop_count(input logic [NODES-1:0] v);
        logic [4*NIBBLES-1:0] padded;
        logic [CNT_W-1:0]     sum;
        logic [3:0]           nib;
        padded = (4*NIBBLES)'(v);
        sum    = '0;
        for (int k = 0; k < NIBBLES; k++)
        begin
            nib = padded[4*k +: 4];
            sum = sum + CNT_W'({2'b00, nib[0]} + {2'b00, nib[1]}
                               + {2'b00, nib[2]} + {2'b00, nib[3]});
        end
        return sum;
    endfunction

endpackage

### hdl/prt_ctrl.sv
module prt_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  prt_pkg::prt_status_t  status,
    output prt_pkg::prt_cmd_t     cmd
);

    prt_pkg::prt_state_t state_reg;
    prt_pkg::prt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = prt_pkg::ST_MATCH;
                end
            end
            prt_pkg::ST_MATCH:
            begin
                state_next = prt_pkg::ST_UPDATE;
            end
            prt_pkg::ST_UPDATE:
            begin
                state_next = prt_pkg::ST_REPORT;
            end
            prt_pkg::ST_REPORT:
            begin
                if (!status.rsp_stall)
                begin
                    state_next = prt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            prt_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            prt_pkg::ST_MATCH:
            begin
                cmd.match = 1'b1;
            end
            prt_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            prt_pkg::ST_REPORT:
            begin
                cmd.report = !status.rsp_stall;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/prt_datapath.sv
module prt_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  prt_pkg::prt_cmd_t     cmd,
    output prt_pkg::prt_status_t  status,
    input  prt_pkg::prt_req_t     req,
    input  logic [3:0]            own_node,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output prt_pkg::prt_rsp_t     rsp
);

    localparam int TE = prt_pkg::TABLE_ENTRIES;
    localparam int NN = prt_pkg::NODES;
    localparam int IW = prt_pkg::IDX_W;

    prt_pkg::prt_req_t                 req_reg;
    logic [TE-1:0]                     valid_reg;
    logic [prt_pkg::LINE_ADDR_BITS-1:0] line_reg [TE];
    logic [NN-1:0]                     starv_reg [TE];
    logic [NN-1:0]                     mark_reg [TE];
    logic [NN-1:0]                     wr_reg [TE];
    logic [IW-1:0]                     idx_reg;
    logic                              found_reg;
    logic                              full_reg;
    logic [2:0]                        err_reg;
    logic                              exists_reg;
    prt_pkg::prt_rsp_t                 rsp_reg;
    logic                              rsp_valid_reg;

    logic [IW-1:0] match_idx;
    logic [IW-1:0] free_idx;
    logic          match_any;

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        match_any = 1'b0;
        for (int i = TE - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && line_reg[i] == req_reg.line_addr)
            begin
                match_idx = IW'(i);
                match_any = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.match)
        begin
            found_reg <= match_any;
            full_reg  <= &valid_reg;
            idx_reg   <= match_any ? match_idx : free_idx;
        end
    end

    logic [NN-1:0] nbit;
    logic [NN-1:0] cur_s;
    logic [NN-1:0] cur_m;
    logic [NN-1:0] cur_w;
    logic [NN-1:0] new_s;
    logic [NN-1:0] new_m;
    logic [NN-1:0] new_w;
    logic          new_valid;
    logic          wr_en;
    logic [2:0]    err_next;
    logic          exists_next;

    always_comb
    begin
        nbit        = prt_pkg::node_onehot(req_reg.node);
        cur_s       = starv_reg[idx_reg];
        cur_m       = mark_reg[idx_reg];
        cur_w       = wr_reg[idx_reg];
        new_s       = cur_s;
        new_m       = cur_m;
        new_w       = cur_w;
        new_valid   = 1'b1;
        wr_en       = 1'b0;
        err_next    = prt_pkg::ERR_OK;
        exists_next = found_reg;
        case (req_reg.func)
            prt_pkg::FUNC_LOCK:
            begin
                if (nbit != '0)
                begin
                    if (found_reg)
                    begin
                        if ((cur_s & nbit) != '0)
                        begin
                            err_next = prt_pkg::ERR_STARVING;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            new_s = cur_s | nbit;
                            new_w = req_reg.is_write ? (cur_w | nbit) : cur_w;
                        end
                    end
                    else if (full_reg)
                    begin
                        err_next = prt_pkg::ERR_TABLE_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        new_s       = nbit;
                        new_m       = '0;
                        new_w       = req_reg.is_write ? nbit : '0;
                        exists_next = 1'b1;
                    end
                end
            end
            prt_pkg::FUNC_UNLOCK:
            begin
                if (!found_reg || nbit == '0 || (cur_s & nbit) == '0)
                begin
                    err_next = prt_pkg::ERR_NOT_HELD;
                end
                else
                begin
                    wr_en = 1'b1;
                    new_s = cur_s & ~nbit;
                    new_m = cur_m & ~nbit;
                    new_w = cur_w & ~nbit;
                    if ((cur_s & ~nbit) == '0)
                    begin
                        new_valid   = 1'b0;
                        new_m       = '0;
                        new_w       = '0;
                        exists_next = 1'b0;
                    end
                end
            end
            prt_pkg::FUNC_MARK:
            begin
                if (found_reg)
                begin
                    wr_en = 1'b1;
                    new_m = cur_s;
                    if (cur_m != '0)
                    begin
                        err_next = prt_pkg::ERR_MARKED;
                    end
                end
            end
            prt_pkg::FUNC_QUERY:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.update && wr_en)
        begin
            valid_reg[idx_reg] <= new_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            err_reg    <= err_next;
            exists_reg <= exists_next;
            if (wr_en)
            begin
                line_reg[idx_reg]  <= req_reg.line_addr;
                starv_reg[idx_reg] <= new_s;
                mark_reg[idx_reg]  <= new_m;
                wr_reg[idx_reg]    <= new_w;
            end
        end
    end

    logic [NN-1:0]         rep_s;
    logic [NN-1:0]         rep_w;
    logic [3:0]            low_node;
    logic                  low_write;
    logic [prt_pkg::CNT_W-1:0] cnt_all;
    logic [prt_pkg::CNT_W-1:0] cnt_read;
    prt_pkg::prt_rsp_t     rsp_next;

    always_comb
    begin
        rep_s     = starv_reg[idx_reg];
        rep_w     = wr_reg[idx_reg];
        low_node  = '0;
        low_write = 1'b0;
        for (int i = NN - 1; i >= 0; i--)
        begin
            if (rep_s[i])
            begin
                low_node  = 4'(i);
                low_write = rep_w[i];
            end
        end
        cnt_all  = prt_pkg::pop_count(rep_s);
        cnt_read = prt_pkg::pop_count(rep_s & ~rep_w);
        rsp_next = '0;
        rsp_next.error     = err_reg;
        rsp_next.may_issue = 1'b1;
        if (exists_reg)
        begin
            rsp_next.locked              = 1'b1;
            rsp_next.smallest_valid      = 1'b1;
            rsp_next.may_issue           = ((rep_s & prt_pkg::node_onehot(own_node)) == '0)
                                           && (mark_reg[idx_reg] == '0);
            rsp_next.smallest_node       = low_node;
            rsp_next.smallest_is_write   = low_write;
            rsp_next.starving_count      = 5'(cnt_all);
            rsp_next.read_starving_count = 5'(cnt_read);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign status.rsp_stall = rsp_valid_reg && !rsp_ready;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

endmodule

### hdl/persistent_request_table_core.sv
// Persistent request table: a 16-entry fully associative table keyed by cache line address
// that tracks starving, marked and write-requesting nodes per line. Each request passes through
// the controller steps capture, associative match over all entries, entry update and
// status report through one shared entry port, and the response register is loaded in the
// report step. req_ready is high only while no request is in flight, and a finished
// response waits in its output register while the next request is accepted. The report
// step holds while an earlier response transfer is still pending. The own node register
// sits at byte address 0 of the APB port and should only be written while idle.
module persistent_request_table_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  prt_pkg::prt_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output prt_pkg::prt_rsp_t  rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    prt_pkg::prt_cmd_t    cmd;
    prt_pkg::prt_status_t status;
    logic [3:0]           own_node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == prt_pkg::ADDR_OWN_NODE)
        begin
            own_node_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == prt_pkg::ADDR_OWN_NODE) ? 32'(own_node_reg) : 32'd0;

    prt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    prt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .own_node  (own_node_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("request accepted while another is in flight");

    a_unlocked_status : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.locked) |->
        (rsp.may_issue && rsp.starving_count == 5'd0 && !rsp.smallest_valid)
    ) else $error("status of an unlocked line is not clear");

    a_locked_counts : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.locked) |->
        (rsp.starving_count != 5'd0 && rsp.read_starving_count <= rsp.starving_count)
    ) else $error("locked line reports inconsistent starving counts");

    a_full_not_locked : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.error == prt_pkg::ERR_TABLE_FULL) |-> !rsp.locked
    ) else $error("table full reported for a locked line");

endmodule

### tb/prt_checker.sv
`timescale 1ns / 100ps

module prt_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  prt_pkg::prt_req_t         req,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  prt_pkg::prt_rsp_t         rsp,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output int                        fail_count,
    output int                        pending,
    output int                        n_checked,
    output int                        n_full,
    output int                        n_remark
);

    logic                               ent_valid [prt_pkg::TABLE_ENTRIES];
    logic [prt_pkg::LINE_ADDR_BITS-1:0] ent_line  [prt_pkg::TABLE_ENTRIES];
    logic [prt_pkg::NODES-1:0]          starve    [prt_pkg::TABLE_ENTRIES];
    logic [prt_pkg::NODES-1:0]          marked    [prt_pkg::TABLE_ENTRIES];
    logic [prt_pkg::NODES-1:0]          wset      [prt_pkg::TABLE_ENTRIES];
    logic [3:0]                         own;
    prt_pkg::prt_rsp_t                  line_status_q [$];

    task automatic report(input string msg);
        if (fail_count < 40)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got %0h, expected %0h", field, got, want));
        end
    endtask

    function automatic prt_pkg::prt_rsp_t apply_request(input prt_pkg::prt_req_t r);
        int                        e;
        int                        f;
        int                        low;
        int                        cnt;
        int                        rcnt;
        logic [prt_pkg::NODES-1:0] nbit;
        logic [prt_pkg::NODES-1:0] s;
        logic                      own_st;
        prt_pkg::prt_rsp_t         o;

        e = -1;
        for (int i = 0; i < prt_pkg::TABLE_ENTRIES; i++)
        begin
            if (e < 0 && ent_valid[i] && ent_line[i] == r.line_addr)
            begin
                e = i;
            end
        end
        nbit = '0;
        if (int'(r.node) < prt_pkg::NODES)
        begin
            nbit[r.node] = 1'b1;
        end
        o = '0;
        o.error = prt_pkg::ERR_OK;

        case (r.func)
            prt_pkg::FUNC_LOCK:
            begin
                if (nbit != '0)
                begin
                    if (e >= 0)
                    begin
                        if ((starve[e] & nbit) != '0)
                        begin
                            o.error = prt_pkg::ERR_STARVING;
                        end
                        else
                        begin
                            starve[e] |= nbit;
                            if (r.is_write)
                            begin
                                wset[e] |= nbit;
                            end
                        end
                    end
                    else
                    begin
                        f = -1;
                        for (int i = 0; i < prt_pkg::TABLE_ENTRIES; i++)
                        begin
                            if (f < 0 && !ent_valid[i])
                            begin
                                f = i;
                            end
                        end
                        if (f < 0)
                        begin
                            o.error = prt_pkg::ERR_TABLE_FULL;
                        end
                        else
                        begin
                            ent_valid[f] = 1'b1;
                            ent_line[f]  = r.line_addr;
                            starve[f]    = nbit;
                            marked[f]    = '0;
                            wset[f]      = r.is_write ? nbit : '0;
                            e            = f;
                        end
                    end
                end
            end
            prt_pkg::FUNC_UNLOCK:
            begin
                if (e < 0 || nbit == '0 || (starve[e] & nbit) == '0)
                begin
                    o.error = prt_pkg::ERR_NOT_HELD;
                end
                else
                begin
                    starve[e] &= ~nbit;
                    marked[e] &= ~nbit;
                    wset[e]   &= ~nbit;
                    if (starve[e] == '0)
                    begin
                        ent_valid[e] = 1'b0;
                        marked[e]    = '0;
                        wset[e]      = '0;
                        e            = -1;
                    end
                end
            end
            prt_pkg::FUNC_MARK:
            begin
                if (e >= 0)
                begin
                    if (marked[e] != '0)
                    begin
                        o.error = prt_pkg::ERR_MARKED;
                    end
                    marked[e] = starve[e];
                end
            end
            default:
            begin
            end
        endcase

        if (e >= 0)
        begin
            s    = starve[e];
            low  = 0;
            cnt  = 0;
            rcnt = 0;
            for (int i = prt_pkg::NODES - 1; i >= 0; i--)
            begin
                if (s[i])
                begin
                    low = i;
                    cnt++;
                    if (!wset[e][i])
                    begin
                        rcnt++;
                    end
                end
            end
            own_st = 1'b0;
            if (int'(own) < prt_pkg::NODES)
            begin
                own_st = s[own];
            end
            o.locked              = 1'b1;
            o.may_issue           = !own_st && marked[e] == '0;
            o.smallest_valid      = 1'b1;
            o.smallest_node       = 4'(low);
            o.smallest_is_write   = (s != '0) && wset[e][low];
            o.starving_count      = 5'(cnt);
            o.read_starving_count = 5'(rcnt);
        end
        else
        begin
            o.may_issue = 1'b1;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        prt_pkg::prt_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < prt_pkg::TABLE_ENTRIES; i++)
            begin
                ent_valid[i] = 1'b0;
                ent_line[i]  = '0;
                starve[i]    = '0;
                marked[i]    = '0;
                wset[i]      = '0;
            end
            own = '0;
            line_status_q.delete();
            fail_count = 0;
            pending    = 0;
            n_checked  = 0;
            n_full     = 0;
            n_remark   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr == {prt_pkg::ADDR_OWN_NODE, 2'b00})
            begin
                own = pwdata[3:0];
            end
            if (rsp_valid && rsp_ready)
            begin
                if (line_status_q.size() == 0)
                begin
                    report("response transfer with no request outstanding");
                end
                else
                begin
                    want = line_status_q.pop_front();
                    n_checked++;
                    check_field("locked", 8'(rsp.locked), 8'(want.locked));
                    check_field("may_issue", 8'(rsp.may_issue), 8'(want.may_issue));
                    check_field("smallest_valid", 8'(rsp.smallest_valid),
                                8'(want.smallest_valid));
                    check_field("smallest_node", 8'(rsp.smallest_node),
                                8'(want.smallest_node));
                    check_field("smallest_is_write", 8'(rsp.smallest_is_write),
                                8'(want.smallest_is_write));
                    check_field("starving_count", 8'(rsp.starving_count),
                                8'(want.starving_count));
                    check_field("read_starving_count", 8'(rsp.read_starving_count),
                                8'(want.read_starving_count));
                    check_field("error", 8'(rsp.error), 8'(want.error));
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_request(req);
                if (want.error == prt_pkg::ERR_TABLE_FULL)
                begin
                    n_full++;
                end
                if (want.error == prt_pkg::ERR_MARKED)
                begin
                    n_remark++;
                end
                line_status_q.push_back(want);
            end
            pending = line_status_q.size();
        end
    end

endmodule

### tb/tb_persistent_request_table_core.sv
`timescale 1ns / 100ps

module tb_persistent_request_table_core;

    localparam int IDLE_LIMIT = 4000;
    localparam int POOL_SIZE  = 24;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    prt_pkg::prt_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    prt_pkg::prt_rsp_t rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [2:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int n_checked;
    int n_full;
    int n_remark;

    int n_sent       = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    bit sender_idles = 1'b1;
    bit hold_rsp     = 1'b0;

    logic [prt_pkg::LINE_ADDR_BITS-1:0] addr_pool [POOL_SIZE];

    always #5 clk = ~clk;

    persistent_request_table_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    prt_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending),
        .n_checked  (n_checked),
        .n_full     (n_full),
        .n_remark   (n_remark)
    );

    function automatic prt_pkg::prt_req_t mk(input logic [1:0] func,
                                             input logic [prt_pkg::LINE_ADDR_BITS-1:0] addr,
                                             input logic [3:0] node, input logic wr);
        prt_pkg::prt_req_t r;
        r.func      = func;
        r.line_addr = addr;
        r.node      = node;
        r.is_write  = wr;
        return r;
    endfunction

    function automatic prt_pkg::prt_req_t random_item(input int pool_lim, input int node_max);
        int                roll;
        prt_pkg::prt_req_t r;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            r.func      = 2'($urandom_range(0, 3));
            r.line_addr = prt_pkg::LINE_ADDR_BITS'({$urandom(), $urandom()});
            r.node      = 4'($urandom_range(0, 15));
            r.is_write  = 1'($urandom_range(0, 1));
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                r.func = prt_pkg::FUNC_LOCK;
            end
            else if (roll < 75)
            begin
                r.func = prt_pkg::FUNC_UNLOCK;
            end
            else if (roll < 85)
            begin
                r.func = prt_pkg::FUNC_MARK;
            end
            else
            begin
                r.func = prt_pkg::FUNC_QUERY;
            end
            r.line_addr = addr_pool[$urandom_range(0, pool_lim)];
            r.node      = 4'($urandom_range(0, node_max));
            r.is_write  = 1'($urandom_range(0, 1));
        end
        return r;
    endfunction

    task automatic send(input prt_pkg::prt_req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        n_sent++;
        gap = 0;
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 7);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left--;
            end
        end
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count, input int pool_lim, input int node_max);
        for (int k = 0; k < count; k++)
        begin
            send(random_item(pool_lim, node_max));
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_own(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {prt_pkg::ADDR_OWN_NODE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    2: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ~rsp_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = prt_pkg::LINE_ADDR_BITS'({$urandom(), $urandom()});
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_own(4'd0);
        send(mk(prt_pkg::FUNC_LOCK,   addr_pool[0], 4'd0,  1'b1));
        send(mk(prt_pkg::FUNC_LOCK,   addr_pool[0], 4'd0,  1'b0));
        send(mk(prt_pkg::FUNC_LOCK,   addr_pool[0], 4'd15, 1'b0));
        send(mk(prt_pkg::FUNC_MARK,   addr_pool[0], 4'd0,  1'b0));
        send(mk(prt_pkg::FUNC_MARK,   addr_pool[0], 4'd0,  1'b0));
        send(mk(prt_pkg::FUNC_UNLOCK, addr_pool[0], 4'd3,  1'b0));
        send(mk(prt_pkg::FUNC_UNLOCK, addr_pool[1], 4'd1,  1'b1));
        send(mk(prt_pkg::FUNC_MARK,   addr_pool[1], 4'd0,  1'b0));
        send(mk(prt_pkg::FUNC_UNLOCK, addr_pool[0], 4'd0,  1'b0));
        send(mk(prt_pkg::FUNC_UNLOCK, addr_pool[0], 4'd15, 1'b0));
        // Fill every entry, then one more line must be refused.
        for (int i = 0; i < prt_pkg::TABLE_ENTRIES; i++)
        begin
            send(mk(prt_pkg::FUNC_LOCK, addr_pool[i], 4'(i), 1'(i)));
        end
        send(mk(prt_pkg::FUNC_LOCK, addr_pool[prt_pkg::TABLE_ENTRIES], 4'd2, 1'b1));

        drain();
        write_own(4'd15);
        run_phase(480, 3, 15);

        drain();
        write_own(4'($urandom_range(1, 14)));
        hold_rsp = 1'b1;
        run_phase(480, POOL_SIZE - 1, 3);

        drain();
        write_own(4'($urandom_range(1, 14)));
        sender_idles = 1'b0;
        run_phase(480, POOL_SIZE - 1, 15);

        drain();
        write_own(4'd0);
        sender_idles = 1'b1;
        run_phase(490, 10, 7);

        drain();
        $display("Sent %0d requests and checked %0d responses over five own-node settings.",
                 n_sent, n_checked);
        $display("Saw %0d table-full refusals and %0d marks on already marked lines.",
                 n_full, n_remark);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
